@@ rtl/pcrs_pkg.sv @@
// shared constants, types and tables for the range-scan binning block
package pcrs_pkg;

  localparam int CoordW = 18;
  localparam int AngW   = 16;
  localparam int RangeW = 17;
  localparam int AtanEntries = 24;

  localparam logic [1:0] OpBegin = 2'd0;
  localparam logic [1:0] OpPoint = 2'd1;
  localparam logic [1:0] OpRead  = 2'd2;

  localparam logic [2:0] RegStart  = 3'd0;
  localparam logic [2:0] RegBins   = 3'd1;
  localparam logic [2:0] RegBpt    = 3'd2;
  localparam logic [2:0] RegMinR   = 3'd3;
  localparam logic [2:0] RegMaxR   = 3'd4;
  localparam logic [2:0] RegHCent  = 3'd5;
  localparam logic [2:0] RegHBand  = 3'd6;

  localparam logic [31:0] InvGain = 32'd39797;

  typedef struct packed {
    logic [15:0] start_angle;
    logic [11:0] bins_in_use;
    logic [23:0] bins_per_turn_q8;
    logic [16:0] min_range_mm;
    logic [16:0] max_range_mm;
    logic signed [17:0] height_center_mm;
    logic [16:0] height_band_mm;
  } cfg_t;

  function automatic logic [15:0] atan_turns(input logic [4:0] i);
    logic [15:0] v;
    v = 16'd0;
    case (i)
      5'd0: v = 16'd8192;
      5'd1: v = 16'd4836;
      5'd2: v = 16'd2555;
      5'd3: v = 16'd1297;
      5'd4: v = 16'd651;
      5'd5: v = 16'd326;
      5'd6: v = 16'd163;
      5'd7: v = 16'd81;
      5'd8: v = 16'd41;
      5'd9: v = 16'd20;
      5'd10: v = 16'd10;
      5'd11: v = 16'd5;
      5'd12: v = 16'd3;
      5'd13: v = 16'd1;
      5'd14: v = 16'd1;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pcrs_cordic.sv @@
// iterative vectoring cordic, one rotation step per cycle
module pcrs_cordic #(
  parameter int Steps = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [18:0]   rx_i,
  input  logic signed [18:0]   ry_i,
  output logic                 done_o,
  output logic signed [28:0]   x_o,
  output logic [15:0]          ang_o
);
  import pcrs_pkg::*;

  localparam int StepW = $clog2(Steps + 1);

  logic signed [28:0] x_q, x_d, y_q, y_d;
  logic [15:0] ang_q, ang_d;
  logic [StepW-1:0] i_q, i_d;
  logic busy_q, busy_d, done_q, done_d;
  logic signed [28:0] xs, ys, x0, y0;
  logic [4:0] i5;

  assign i5 = 5'(i_q);
  // arithmetic shift is a floor shift
  assign xs = x_q >>> i_q;
  assign ys = y_q >>> i_q;
  assign x0 = {{2{rx_i[18]}}, rx_i, 8'd0};
  assign y0 = {{2{ry_i[18]}}, ry_i, 8'd0};

  always_comb begin
    x_d = x_q; y_d = y_q; ang_d = ang_q; i_d = i_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      if (x0 < 0) begin
        x_d = -x0; y_d = -y0; ang_d = 16'd32768;
      end else begin
        x_d = x0; y_d = y0; ang_d = 16'd0;
      end
      i_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_d = x_q + ys; y_d = y_q - xs; ang_d = ang_q + atan_turns(i5);
      end else begin
        x_d = x_q - ys; y_d = y_q + xs; ang_d = ang_q - atan_turns(i5);
      end
      i_d = i_q + 1'b1;
      if (i_q == StepW'(Steps - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    ang_q <= ang_d;
  end

  assign done_o = done_q;
  assign x_o = x_q;
  assign ang_o = ang_q;
endmodule

@@ rtl/pcrs_serial_mul.sv @@
// shift-and-add multiplier, one multiplier bit per cycle
module pcrs_serial_mul #(
  parameter int AW = 32,
  parameter int BW = 24
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [AW-1:0]   a_i,
  input  logic [BW-1:0]   b_i,
  output logic            done_o,
  output logic [AW+BW-1:0] p_o
);
  localparam int CntW = $clog2(BW + 1);

  logic [AW+BW-1:0] acc_q, acc_d, a_q, a_d;
  logic [BW-1:0] b_q, b_d;
  logic [CntW-1:0] n_q, n_d;
  logic busy_q, busy_d, done_q, done_d;

  always_comb begin
    acc_d = acc_q; a_d = a_q; b_d = b_q; n_d = n_q;
    busy_d = busy_q; done_d = 1'b0;
    if (start_i) begin
      acc_d = '0;
      a_d = (AW+BW)'(a_i);
      b_d = b_i;
      n_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (b_q[0]) acc_d = acc_q + a_q;
      a_d = a_q << 1;
      b_d = b_q >> 1;
      n_d = n_q + 1'b1;
      if (n_q == CntW'(BW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      n_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    a_q <= a_d;
    b_q <= b_d;
  end

  assign done_o = done_q;
  assign p_o = acc_q;
endmodule

@@ rtl/point_cloud_to_range_scan.sv @@
// top level: point binning with cordic, serial multiplier and bin store
// sequence: begin frame runs a clearing pass over the hit marks; read goes
// through the memory read and the output register; point runs the cordic
// loop, two products on the shift-and-add multiplier, check, store update
// throughput: one item at a time; the next is taken once the last finishes
// reset: async active low, control and config registers reset, then a clearing pass
module point_cloud_to_range_scan #(
  parameter int BIN_DEPTH    = 2048,
  parameter int CORDIC_STEPS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   op_i,
  input  logic signed [17:0] coord_x_i,
  input  logic signed [17:0] coord_y_i,
  input  logic signed [17:0] coord_z_i,
  input  logic         height_present_i,
  input  logic         coords_finite_i,
  input  logic [15:0]  frame_yaw_i,
  input  logic [10:0]  read_index_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [16:0]  bin_range_mm_o,
  output logic         bin_empty_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import pcrs_pkg::*;

  localparam int IdxW = $clog2(BIN_DEPTH);

  // sequencer codes
  localparam logic [3:0] StIdle   = 4'd0;
  localparam logic [3:0] StCordic = 4'd1;
  localparam logic [3:0] StDist   = 4'd2;
  localparam logic [3:0] StBin    = 4'd3;
  localparam logic [3:0] StCheck  = 4'd4;
  localparam logic [3:0] StRdMem  = 4'd5;
  localparam logic [3:0] StUpdate = 4'd6;
  localparam logic [3:0] StRead   = 4'd7;
  localparam logic [3:0] StRdOut  = 4'd8;
  localparam logic [3:0] StOut    = 4'd9;
  localparam logic [3:0] StDistS  = 4'd10;
  localparam logic [3:0] StBinS   = 4'd11;
  localparam logic [3:0] StClear  = 4'd12;

  // configuration registers
  cfg_t cfg_q;
  logic [2:0] reg_idx;
  logic cfg_wr;
  assign reg_idx = paddr[4:2];
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_angle <= 16'd32768;
      cfg_q.bins_in_use <= 12'd1258;
      cfg_q.bins_per_turn_q8 <= 24'd321700;
      cfg_q.min_range_mm <= 17'd50;
      cfg_q.max_range_mm <= 17'd30000;
      cfg_q.height_center_mm <= 18'sd600;
      cfg_q.height_band_mm <= 17'd500;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegStart: cfg_q.start_angle <= pwdata[15:0];
        RegBins:  cfg_q.bins_in_use <= pwdata[11:0];
        RegBpt:   cfg_q.bins_per_turn_q8 <= pwdata[23:0];
        RegMinR:  cfg_q.min_range_mm <= pwdata[16:0];
        RegMaxR:  cfg_q.max_range_mm <= pwdata[16:0];
        RegHCent: cfg_q.height_center_mm <= pwdata[17:0];
        RegHBand: cfg_q.height_band_mm <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      RegStart: prdata = 32'(cfg_q.start_angle);
      RegBins:  prdata = 32'(cfg_q.bins_in_use);
      RegBpt:   prdata = 32'(cfg_q.bins_per_turn_q8);
      RegMinR:  prdata = 32'(cfg_q.min_range_mm);
      RegMaxR:  prdata = 32'(cfg_q.max_range_mm);
      RegHCent: prdata = 32'(signed'(cfg_q.height_center_mm));
      RegHBand: prdata = 32'(cfg_q.height_band_mm);
      default:  prdata = 32'd0;
    endcase
  end

  // frame state
  logic signed [17:0] shift_x_q, shift_y_q;
  logic [15:0] heading_q;

  // sequencer
  logic [3:0] st_q;
  logic [IdxW-1:0] clr_q;
  logic [IdxW-1:0] bin_q;
  logic [16:0] dist_q;
  logic [15:0] ang_q;
  logic dist_big_q, bin_bad_q;
  logic [10:0] rd_idx_q;
  logic rd_oor_q;
  logic [16:0] mem_rd_q;
  logic hit_rd_q;
  logic [16:0] out_range_q;
  logic out_empty_q, out_valid_q;
  logic out_load;

  // nearest distance per bin and the per-bin hit marks
  logic [16:0] nearest_mem [BIN_DEPTH];
  logic        hit_mem [BIN_DEPTH];

  logic accept;
  assign in_ready_o = (st_q == StIdle);
  assign accept = in_valid_i && in_ready_o;

  // result register is loaded once the previous item has gone
  assign out_load = (st_q == StOut) && (!out_valid_q || out_ready_i);

  // height test on the incoming item
  logic signed [19:0] dz;
  logic [19:0] adz;
  logic drop_early;
  assign dz = 20'(coord_z_i) - 20'(cfg_q.height_center_mm);
  assign adz = dz[19] ? 20'(-dz) : 20'(dz);
  assign drop_early = !coords_finite_i ||
                      (height_present_i && (adz > 20'(cfg_q.height_band_mm)));

  // cordic
  logic cor_start, cor_done;
  logic signed [28:0] cor_x;
  logic [15:0] cor_ang;
  assign cor_start = accept && (op_i == OpPoint) && !drop_early;

  pcrs_cordic #(.Steps(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(cor_start),
    .rx_i(19'(coord_x_i) + 19'(shift_x_q)),
    .ry_i(19'(coord_y_i) + 19'(shift_y_q)),
    .done_o(cor_done), .x_o(cor_x), .ang_o(cor_ang)
  );

  // shared multiplier: distance, then bin
  logic mul_start, mul_done;
  logic [31:0] mul_a;
  logic [23:0] mul_b;
  logic [55:0] mul_p;
  logic [28:0] xpos_q;

  pcrs_serial_mul #(.AW(32), .BW(24)) u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .p_o(mul_p)
  );

  logic [15:0] rel;
  assign rel = ang_q - heading_q - cfg_q.start_angle;
  assign mul_start = (st_q == StDistS) || (st_q == StBinS);
  assign mul_a = (st_q == StDistS) ? 32'(xpos_q) : 32'(rel);
  assign mul_b = (st_q == StDistS) ? InvGain[23:0] : cfg_q.bins_per_turn_q8;

  logic [55:0] rnd;
  assign rnd = mul_p + 56'(24'h800000);

  logic [IdxW-1:0] rd_addr;
  assign rd_addr = (st_q == StRead) ? IdxW'(rd_idx_q) : bin_q;

  always_ff @(posedge clk_i) begin
    if (st_q == StRdMem || st_q == StRead) begin
      mem_rd_q <= nearest_mem[rd_addr];
      hit_rd_q <= hit_mem[rd_addr];
    end
    if (st_q == StUpdate &&
        (!hit_rd_q || dist_q < mem_rd_q)) nearest_mem[bin_q] <= dist_q;
    // clearing pass walks one mark per cycle
    if (st_q == StClear) hit_mem[clr_q] <= 1'b0;
    else if (st_q == StUpdate) hit_mem[bin_q] <= 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear;
      clr_q <= '0;
      shift_x_q <= '0;
      shift_y_q <= '0;
      heading_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      case (st_q)
        StIdle: if (accept) begin
          case (op_i)
            OpBegin: begin
              shift_x_q <= coord_x_i;
              shift_y_q <= coord_y_i;
              heading_q <= frame_yaw_i;
              clr_q <= '0;
              st_q <= StClear;
            end
            OpPoint: if (!drop_early) st_q <= StCordic;
            OpRead: st_q <= StRead;
            default: ;
          endcase
        end
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == IdxW'(BIN_DEPTH - 1)) st_q <= StIdle;
        end
        StCordic: if (cor_done) st_q <= StDistS;
        StDistS: st_q <= StDist;
        StDist: if (mul_done) st_q <= StBinS;
        StBinS: st_q <= StBin;
        StBin: if (mul_done) st_q <= StCheck;
        StCheck: st_q <= (bin_bad_q || dist_big_q) ? StIdle : StRdMem;
        StRdMem: st_q <= StUpdate;
        StUpdate: st_q <= StIdle;
        StRead: st_q <= StRdOut;
        StRdOut: st_q <= StOut;
        StOut: if (out_load) st_q <= StIdle;
        default: st_q <= StIdle;
      endcase
    end
  end

  logic [31:0] bin_full;
  assign bin_full = rnd[55:24];
  logic [31:0] dist_full;
  assign dist_full = rnd[55:24];

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_idx_q <= read_index_i;
      rd_oor_q <= (32'(read_index_i) >= 32'(BIN_DEPTH));
    end
    if (cor_done) begin
      xpos_q <= cor_x[28] ? '0 : cor_x;
      ang_q <= cor_ang;
    end
    if (st_q == StDist && mul_done) begin
      dist_q <= dist_full[16:0];
      dist_big_q <= (dist_full > 32'(cfg_q.max_range_mm)) ||
                    (dist_full < 32'(cfg_q.min_range_mm));
    end
    if (st_q == StBin && mul_done) begin
      bin_q <= bin_full[IdxW-1:0];
      bin_bad_q <= (bin_full >= 32'(cfg_q.bins_in_use)) ||
                   (bin_full >= 32'(BIN_DEPTH));
    end
    if (out_load) begin
      if (!rd_oor_q && hit_rd_q) begin
        out_range_q <= mem_rd_q;
        out_empty_q <= 1'b0;
      end else begin
        out_range_q <= '0;
        out_empty_q <= 1'b1;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign bin_range_mm_o = out_range_q;
  assign bin_empty_o = out_empty_q;
endmodule

@@ rtl/pcrs_checker.sv @@
// port-level checks on the binning block, bound to the top level
module pcrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [16:0] bin_range_mm_o,
  input logic        bin_empty_o,
  input logic        pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(bin_range_mm_o) && $stable(bin_empty_o))
    else $error("output item dropped or changed while stalled");
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bin_empty_o |-> bin_range_mm_o == 17'd0)
    else $error("empty bin reports a range");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_out_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !$isunknown({bin_range_mm_o, bin_empty_o}))
    else $error("output item carries unknown bits");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i)
    else $error("input item withdrawn before acceptance");
endmodule

bind point_cloud_to_range_scan pcrs_checker u_pcrs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .bin_range_mm_o, .bin_empty_o, .pready
);
